/* src/ymcr_pkg.sv */
`timescale 1ns / 1ps

package ymcr_pkg;

   // Protocol characters.
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_CA  = 8'h18;
   localparam logic [7:0] CH_UA  = 8'h41;
   localparam logic [7:0] CH_LA  = 8'h61;

   // Session end codes.
   localparam logic [1:0] END_FINISHED   = 2'd0;
   localparam logic [1:0] END_CANCELLED  = 2'd1;
   localparam logic [1:0] END_UNEXPECTED = 2'd2;
   localparam logic [1:0] END_BAD_SEQ    = 2'd3;

   // Packet verdicts.
   localparam logic [1:0] VERDICT_NONE = 2'd0;
   localparam logic [1:0] VERDICT_GOOD = 2'd1;
   localparam logic [1:0] VERDICT_BAD  = 2'd2;

   localparam logic [30:0] FILE_SIZE_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        pay_valid;
      logic [7:0]  pay_byte;
      logic [1:0]  verdict;
      logic        done_res;
      logic [1:0]  end_code;
      logic [30:0] file_size;
      logic        last;
   } rsp_item_type;

   // CRC-16/XMODEM update by one byte, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

/* src/ymcr_core.sv */
`timescale 1ns / 1ps

module ymcr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  func,
   input  logic [7:0]            rx_byte,
   output logic [1:0]            res_count,
   output ymcr_pkg::rsp_item_type res0,
   output ymcr_pkg::rsp_item_type res1
);
   import ymcr_pkg::*;

   typedef enum logic [6:0] {
      PH_START = 7'b0000001,
      PH_HEAD  = 7'b0000010,
      PH_DWAIT = 7'b0000100,
      PH_DATA  = 7'b0001000,
      PH_EWAIT = 7'b0010000,
      PH_EHEAD = 7'b0100000,
      PH_DONE  = 7'b1000000
   } phase_type;

   localparam logic [1:0] SP_NAME  = 2'd0;
   localparam logic [1:0] SP_DIGIT = 2'd1;
   localparam logic [1:0] SP_END   = 2'd2;

   localparam logic [10:0] HDR_CRC_HI   = 11'd130;
   localparam logic [10:0] SHORT_CRC_HI = 11'd130;
   localparam logic [10:0] LONG_CRC_HI  = 11'd1026;

   phase_type   phase_ff, phase_in;
   logic [10:0] pos_ff, pos_in;
   logic        long_ff, long_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crch_ff, crch_in;
   logic [30:0] size_ff, size_in;
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  end_ff, end_in;

   logic [10:0] pos_inc;
   logic [15:0] crc_next;
   logic        crc_ok;
   logic [10:0] data_crc_hi;
   logic        is_digit;
   logic [3:0]  digit;
   logic [30:0] size_limit;
   logic [33:0] size_mul;
   logic [30:0] size_digit;

   logic        r0_txv;
   logic [7:0]  r0_txb;
   logic        r0_pv;
   logic [7:0]  r0_pb;
   logic [1:0]  r0_verdict;

   assign pos_inc     = pos_ff + 11'd1;
   assign crc_next    = crc_byte(crc_ff, rx_byte);
   assign crc_ok      = (crc_ff == {crch_ff, rx_byte});
   assign data_crc_hi = long_ff ? LONG_CRC_HI : SHORT_CRC_HI;

   // Decimal accumulate with saturation; the limit is (max - digit) / 10.
   assign is_digit   = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
   assign digit      = rx_byte[3:0];
   assign size_limit = (digit >= 4'd8) ? 31'd214748363 : 31'd214748364;
   assign size_mul   = {size_ff, 3'b000} + {2'b00, size_ff, 1'b0} + {30'd0, digit};
   assign size_digit = (size_ff > size_limit) ? FILE_SIZE_MAX : size_mul[30:0];

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      long_in    = long_ff;
      crc_in     = crc_ff;
      crch_in    = crch_ff;
      size_in    = size_ff;
      mode_in    = mode_ff;
      end_in     = end_ff;
      res_count  = 2'd0;
      r0_txv     = 1'b0;
      r0_txb     = 8'h00;
      r0_pv      = 1'b0;
      r0_pb      = 8'h00;
      r0_verdict = VERDICT_NONE;

      if (fire && (phase_ff != PH_DONE)) begin
         if (func) begin
            if (phase_ff == PH_START) begin
               res_count = 2'd1;
               r0_txv    = 1'b1;
               r0_txb    = CH_C;
            end
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (rx_byte == CH_SOH) begin
                     phase_in = PH_HEAD;
                     pos_in   = 11'd0;
                     crc_in   = 16'h0000;
                     size_in  = 31'd0;
                     mode_in  = SP_NAME;
                  end else begin
                     res_count = 2'd1;
                     r0_txv    = 1'b1;
                     r0_txb    = CH_C;
                  end
               end
               PH_HEAD, PH_EHEAD: begin
                  pos_in = pos_inc;
                  if (pos_ff == 11'd0) begin
                     if (rx_byte != 8'h00) begin
                        end_in    = END_BAD_SEQ;
                        phase_in  = PH_DONE;
                        res_count = 2'd1;
                     end
                  end else if (pos_ff == 11'd1) begin
                     if (rx_byte != 8'hFF) begin
                        end_in    = END_BAD_SEQ;
                        phase_in  = PH_DONE;
                        res_count = 2'd1;
                     end
                  end else if (pos_ff < HDR_CRC_HI) begin
                     crc_in = crc_next;
                     // The file size is only taken from the opening header.
                     if (phase_ff == PH_HEAD) begin
                        if (mode_ff == SP_NAME) begin
                           if (rx_byte == 8'h00) begin
                              mode_in = SP_DIGIT;
                           end
                        end else if (mode_ff == SP_DIGIT) begin
                           if (is_digit) begin
                              size_in = size_digit;
                           end else begin
                              mode_in = SP_END;
                           end
                        end
                     end
                  end else if (pos_ff == HDR_CRC_HI) begin
                     crch_in = rx_byte;
                  end else begin
                     pos_in = 11'd0;
                     r0_txv = 1'b1;
                     if (phase_ff == PH_HEAD) begin
                        // Opening header CRC is not checked.
                        phase_in  = PH_DWAIT;
                        res_count = 2'd2;
                        r0_txb    = CH_ACK;
                     end else if (crc_ok) begin
                        end_in    = END_FINISHED;
                        phase_in  = PH_DONE;
                        res_count = 2'd1;
                        r0_txb    = CH_ACK;
                     end else begin
                        phase_in  = PH_EWAIT;
                        res_count = 2'd2;
                        r0_txb    = CH_NAK;
                     end
                  end
               end
               PH_DWAIT: begin
                  if ((rx_byte == CH_SOH) || (rx_byte == CH_STX)) begin
                     long_in  = (rx_byte == CH_STX);
                     phase_in = PH_DATA;
                     pos_in   = 11'd0;
                     crc_in   = 16'h0000;
                  end else if (rx_byte == CH_EOT) begin
                     phase_in  = PH_EWAIT;
                     res_count = 2'd2;
                     r0_txv    = 1'b1;
                     r0_txb    = CH_ACK;
                  end else if ((rx_byte == CH_CA) || (rx_byte == CH_UA) ||
                               (rx_byte == CH_LA)) begin
                     end_in    = END_CANCELLED;
                     phase_in  = PH_DONE;
                     res_count = 2'd1;
                  end else begin
                     end_in    = END_UNEXPECTED;
                     phase_in  = PH_DONE;
                     res_count = 2'd1;
                  end
               end
               PH_DATA: begin
                  pos_in = pos_inc;
                  if (pos_ff < 11'd2) begin
                     // Sequence and complement bytes are skipped.
                  end else if (pos_ff < data_crc_hi) begin
                     crc_in    = crc_next;
                     res_count = 2'd1;
                     r0_pv     = 1'b1;
                     r0_pb     = rx_byte;
                  end else if (pos_ff == data_crc_hi) begin
                     crch_in = rx_byte;
                  end else begin
                     pos_in     = 11'd0;
                     phase_in   = PH_DWAIT;
                     res_count  = 2'd1;
                     r0_txv     = 1'b1;
                     r0_txb     = crc_ok ? CH_ACK : CH_NAK;
                     r0_verdict = crc_ok ? VERDICT_GOOD : VERDICT_BAD;
                  end
               end
               PH_EWAIT: begin
                  if (rx_byte == CH_SOH) begin
                     phase_in = PH_EHEAD;
                     pos_in   = 11'd0;
                     crc_in   = 16'h0000;
                  end else begin
                     end_in    = END_UNEXPECTED;
                     phase_in  = PH_DONE;
                     res_count = 2'd1;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   // Status fields reflect the state after this item.
   always_comb begin
      res0.tx_valid  = r0_txv;
      res0.tx_byte   = r0_txb;
      res0.pay_valid = r0_pv;
      res0.pay_byte  = r0_pb;
      res0.verdict   = r0_verdict;
      res0.done_res  = (phase_in == PH_DONE);
      res0.end_code  = end_in;
      res0.file_size = size_in;
      res0.last      = (res_count == 2'd1);

      // A second result is always the 'C' that asks for the next packet.
      res1           = res0;
      res1.tx_valid  = 1'b1;
      res1.tx_byte   = CH_C;
      res1.pay_valid = 1'b0;
      res1.pay_byte  = 8'h00;
      res1.verdict   = VERDICT_NONE;
      res1.last      = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pos_ff   <= 11'd0;
         long_ff  <= 1'b0;
         crc_ff   <= 16'h0000;
         crch_ff  <= 8'h00;
         size_ff  <= 31'd0;
         mode_ff  <= SP_NAME;
         end_ff   <= END_FINISHED;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         long_ff  <= long_in;
         crc_ff   <= crc_in;
         crch_ff  <= crch_in;
         size_ff  <= size_in;
         mode_ff  <= mode_in;
         end_ff   <= end_in;
      end
   end

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (res_count == 2'd0))
      else $error("result produced after session end");

   a_verdict_with_reply: assert property (@(posedge clock) disable iff (reset)
      (res_count != 2'd0 && res0.verdict != VERDICT_NONE) |-> res0.tx_valid)
      else $error("packet verdict without ACK or NAK");

   a_pair_is_reply: assert property (@(posedge clock) disable iff (reset)
      (res_count == 2'd2) |-> (res0.tx_valid && !res0.pay_valid && !res0.done_res))
      else $error("paired result without leading reply");

endmodule

/* src/ymcr_outq.sv */
`timescale 1ns / 1ps

module ymcr_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  ymcr_pkg::rsp_item_type push0,
   input  ymcr_pkg::rsp_item_type push1,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ymcr_pkg::rsp_item_type out_item
);
   import ymcr_pkg::*;

   rsp_item_type entry_ff [4];
   logic [1:0]   head_ff, head_in;
   logic [1:0]   tail_ff, tail_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;
   logic [1:0]   tail_next;

   assign out_valid = (count_ff != 3'd0);
   assign out_item  = entry_ff[head_ff];
   assign pop       = out_valid && out_ready;
   // Space for the two results that one item can cause.
   assign room      = (count_ff <= 3'd2);
   assign tail_next = tail_ff + 2'd1;

   always_comb begin
      head_in  = head_ff + {1'b0, pop};
      tail_in  = tail_ff + push_count;
      count_in = count_ff + {1'b0, push_count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[tail_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[tail_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 2'd0;
         tail_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> room)
      else $error("result queue written without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff[1:0] == (tail_ff - head_ff)))
      else $error("result queue pointers disagree with count");

endmodule

/* src/ymodem_crc_receiver.sv */
`timescale 1ns / 1ps

// YMODEM-CRC receive protocol engine. Each input item is either one byte
// from the sender (req_tuser low, byte in req_tdata) or a notice that the
// receive wait timed out (req_tuser high). Each item causes zero, one or
// two result items on the rsp_ channel: a reply byte to send ('C', ACK or
// NAK), a pending payload byte of the current data packet, a commit or
// discard verdict at packet end, plus the session status and the file size
// decoded from the opening header. rsp_tlast marks the final result of an
// input item; items that cause nothing produce no result.
// An accepted input item is held in an input register and is processed
// once the result queue has room for its results, which are written into
// the queue and offered from there. One input item is taken every cycle as
// long as the four-entry result queue holds at most two items, so
// throughput is one item per cycle while the result side keeps up; the
// queue output rate (one result per cycle) is the limit when items cause
// two results.
// Reset clears the protocol state to the start phase and empties the
// queue. When the result side stalls, results wait in the queue; the input
// side stops accepting while its held item waits for queue room.
module ymodem_crc_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] tx_valid, [8:1] tx_byte, [9] pay_valid, [17:10] pay_byte,
   // [19:18] verdict, [20] done_res, [22:21] end_code,
   // [53:23] file_size, [55:54] zero
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast
);
   import ymcr_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic         in_func_ff;
   logic [7:0]   in_byte_ff;
   logic         fire;
   logic         room;
   logic [1:0]   res_count;
   logic [1:0]   push_count;
   rsp_item_type res0;
   rsp_item_type res1;
   rsp_item_type out_item;

   // The held item is processed once the queue has room for its results.
   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);
   assign push_count  = fire ? res_count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   ymcr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .func      (in_func_ff),
      .rx_byte   (in_byte_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   ymcr_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .room       (room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   assign rsp_tdata = {2'b00, out_item.file_size, out_item.end_code, out_item.done_res,
                       out_item.verdict, out_item.pay_byte, out_item.pay_valid,
                       out_item.tx_byte, out_item.tx_valid};
   assign rsp_tlast = out_item.last;

endmodule
